// ----- hdl/cds_pkg.sv -----
// ----------------------------------------------------------------------------
// cds_pkg: shared types and constants of the calendar date stepper
// Operation codes, sequencer states, calendar tables and the constants of
// the reciprocal division by one hundred.
// ----------------------------------------------------------------------------
package cds_pkg;

  // default widths of the year and the day count
  localparam int YEAR_BITS_DEF  = 14;
  localparam int COUNT_BITS_DEF = 16;

  // fixed field widths
  localparam int OP_W    = 2;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DIFF_W  = 23;

  // highest year that the calendar supports
  localparam int YEAR_CAP = 9999;

  // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x below 91180
  localparam int RECIP_W     = 17;
  localparam int RECIP_100   = 83887;
  localparam int RECIP_SHIFT = 23;

  localparam int DAYS_PER_YEAR = 365;
  localparam int LEAP_REM      = 99;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 2'd0,
    OP_ADD  = 2'd1,
    OP_SUB  = 2'd2,
    OP_DIFF = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_STEP,
    S_LEAP_MUL,
    S_LEAP_SET,
    S_DIFF_MUL,
    S_DIFF_DIV,
    S_DIFF_SUM1,
    S_DIFF_SUM2,
    S_FINISH
  } state_e;

  // length of a month, given the leap flag of its year
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m) inside
      4'd2:                   len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

  // days of a common year that come before the first of a month
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] n;
    unique case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

// ----- hdl/cds_if.sv -----
// ----------------------------------------------------------------------------
// cds_in_if / cds_out_if: request and result channels
// Valid/ready channels carrying one operation request and one result.
// ----------------------------------------------------------------------------
interface cds_in_if #(
  parameter int YEAR_BITS  = 14,
  parameter int COUNT_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            operation;
  logic [YEAR_BITS-1:0]  in_year;
  logic [3:0]            in_month;
  logic [4:0]            in_day;
  logic [COUNT_BITS-1:0] day_count;

  modport source (output valid, operation, in_year, in_month, in_day, day_count,
                  input ready);
  modport sink   (input valid, operation, in_year, in_month, in_day, day_count,
                  output ready);
endinterface

interface cds_out_if #(
  parameter int YEAR_BITS = 14
);
  logic                 valid;
  logic                 ready;
  logic [YEAR_BITS-1:0] out_year;
  logic [3:0]           out_month;
  logic [4:0]           out_day;
  logic signed [22:0]   day_difference;
  logic                 error;

  modport source (output valid, out_year, out_month, out_day, day_difference, error,
                  input ready);
  modport sink   (input valid, out_year, out_month, out_day, day_difference, error,
                  output ready);
endinterface

// ----- hdl/calendar_date_stepper_top.sv -----
// ----------------------------------------------------------------------------
// calendar_date_stepper_top: Gregorian date register with day stepping
// Holds one date; loads it, steps it forward or back by a day count, or
// gives its signed day distance to a given date.
// ----------------------------------------------------------------------------
// Usage
//   in_i carries one request transaction (operation, date, day count); out_o
//   returns one result transaction per request: the stored date afterwards,
//   the day difference (zero except for difference) and an error flag.
//   A request is taken only while the sequencer is idle; one request is in
//   work at a time.
// Sequence from acceptance to the result being registered
//   load              leap flag refresh (S_LEAP_MUL, S_LEAP_SET), then S_FINISH
//   add / subtract    one day per cycle in the stepping state; every year
//                     boundary crossed passes through S_LEAP_MUL and
//                     S_LEAP_SET before stepping on; then S_FINISH
//   difference        each of the two dates goes twice through the shared
//                     multiplier ((year - 1) / 100, then 365 * (year - 1))
//                     and twice through the accumulator
//   rejected date     a load or difference with a bad date goes to S_FINISH
// Reset sets the date to January 1, 2000 and empties the result register.
// A stalled receiver holds the result register; a finished request waits
// there until the register frees, and no new request is taken meanwhile.
// ----------------------------------------------------------------------------
module calendar_date_stepper_top #(
  parameter int COUNT_BITS = cds_pkg::COUNT_BITS_DEF,
  parameter int YEAR_BITS  = cds_pkg::YEAR_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cds_in_if.sink     in_i,
  cds_out_if.source  out_o
);

  localparam int MonthW = cds_pkg::MONTH_W;
  localparam int DayW   = cds_pkg::DAY_W;
  localparam int DiffW  = cds_pkg::DIFF_W;
  localparam int ProdW  = YEAR_BITS + cds_pkg::RECIP_W;
  localparam int QW     = ProdW - cds_pkg::RECIP_SHIFT;
  localparam int YearLimitRaw = (1 << YEAR_BITS) - 1;
  localparam int YearMaxInt = (YearLimitRaw < cds_pkg::YEAR_CAP) ? YearLimitRaw
                                                                 : cds_pkg::YEAR_CAP;
  localparam logic [YEAR_BITS-1:0] YearMax = YEAR_BITS'(YearMaxInt);
  localparam logic [YEAR_BITS-1:0] YearOne = YEAR_BITS'(1);

  // state and registers
  cds_pkg::state_e        state_q, state_d;
  cds_pkg::op_e           op_q, op_d;
  logic [YEAR_BITS-1:0]   cur_year_q, cur_year_d;
  logic [MonthW-1:0]      cur_month_q, cur_month_d;
  logic [DayW-1:0]        cur_day_q, cur_day_d;
  logic                   leap_q, leap_d;
  logic [COUNT_BITS-1:0]  cnt_q, cnt_d;
  logic                   err_q, err_d;
  logic [DiffW-1:0]       acc_q, acc_d;
  logic                   phase_q, phase_d;
  logic                   out_valid_q, out_valid_d;

  // payload registers
  logic [YEAR_BITS-1:0]   yr_in_q;
  logic [MonthW-1:0]      mo_in_q;
  logic [DayW-1:0]        dy_in_q;
  logic [ProdW-1:0]       prod_q;
  logic [QW-1:0]          q100_q;
  logic                   dleap_q;
  logic [YEAR_BITS-1:0]   out_year_q;
  logic [MonthW-1:0]      out_month_q;
  logic [DayW-1:0]        out_day_q;
  logic [DiffW-1:0]       out_diff_q;
  logic                   out_err_q;

  // datapath signals
  cds_pkg::op_e           op_in;
  logic                   in_date_ok;
  logic [YEAR_BITS-1:0]   sel_year;
  logic [MonthW-1:0]      sel_month;
  logic [DayW-1:0]        sel_day;
  logic [YEAR_BITS-1:0]   p_year;
  logic [cds_pkg::RECIP_W-1:0] mul_b;
  logic [ProdW-1:0]       prod_d;
  logic                   prod_en;
  logic [QW-1:0]          q100;
  logic [YEAR_BITS-1:0]   rem100;
  logic                   leap_calc;
  logic [DiffW-1:0]       term_years;
  logic [DiffW-1:0]       term_days;
  logic                   out_load;
  logic                   in_take;

  assign op_in   = cds_pkg::op_e'(in_i.operation);
  assign in_take = in_i.valid && in_i.ready;

  // range check of a given date
  assign in_date_ok = (in_i.in_year >= YearOne) && (in_i.in_year <= YearMax) &&
                      (in_i.in_month >= MonthW'(1)) && (in_i.in_month <= MonthW'(12)) &&
                      (in_i.in_day != '0);

  // date under work: the stored one, or the given one in the second pass
  assign sel_year  = phase_q ? yr_in_q : cur_year_q;
  assign sel_month = phase_q ? mo_in_q : cur_month_q;
  assign sel_day   = phase_q ? dy_in_q : cur_day_q;
  assign p_year    = sel_year - YearOne;

  // shared multiplier: p * reciprocal of 100, or p * 365
  assign mul_b  = (state_q == cds_pkg::S_DIFF_DIV) ?
                  cds_pkg::RECIP_W'(cds_pkg::DAYS_PER_YEAR) :
                  cds_pkg::RECIP_W'(cds_pkg::RECIP_100);
  assign prod_d = ProdW'(p_year) * ProdW'(mul_b);
  assign prod_en = (state_q == cds_pkg::S_LEAP_MUL) || (state_q == cds_pkg::S_DIFF_MUL) ||
                   (state_q == cds_pkg::S_DIFF_DIV);

  // leap rule from the registered quotient: year % 100 == 0 when p % 100 == 99
  assign q100      = prod_q[ProdW-1:cds_pkg::RECIP_SHIFT];
  assign rem100    = p_year - YEAR_BITS'(YEAR_BITS'(q100) * YEAR_BITS'(100));
  assign leap_calc = (sel_year[1:0] == 2'b00) &&
                     ((rem100 != YEAR_BITS'(cds_pkg::LEAP_REM)) || (q100[1:0] == 2'b11));

  // day number parts: 365p + p/4 - p/100 + p/400, then month offset and day
  assign term_years = DiffW'(prod_q) + DiffW'(p_year >> 2) - DiffW'(q100_q) +
                      DiffW'(q100_q >> 2);
  assign term_days  = DiffW'(cds_pkg::days_before(sel_month)) +
                      DiffW'((sel_month > MonthW'(2)) && dleap_q) + DiffW'(sel_day);

  // sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cur_year_d  = cur_year_q;
    cur_month_d = cur_month_q;
    cur_day_d   = cur_day_q;
    leap_d      = leap_q;
    cnt_d       = cnt_q;
    err_d       = err_q;
    acc_d       = acc_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_load    = 1'b0;
    unique case (state_q)
      cds_pkg::S_IDLE: begin
        if (in_i.valid) begin
          op_d    = op_in;
          err_d   = 1'b0;
          acc_d   = '0;
          phase_d = 1'b0;
          cnt_d   = in_i.day_count;
          unique case (op_in)
            cds_pkg::OP_LOAD: begin
              if (in_date_ok) begin
                cur_year_d  = in_i.in_year;
                cur_month_d = in_i.in_month;
                cur_day_d   = in_i.in_day;
                state_d     = cds_pkg::S_LEAP_MUL;
              end else begin
                err_d   = 1'b1;
                state_d = cds_pkg::S_FINISH;
              end
            end
            cds_pkg::OP_ADD, cds_pkg::OP_SUB: begin
              state_d = cds_pkg::S_STEP;
            end
            default: begin
              if (in_date_ok) begin
                state_d = cds_pkg::S_DIFF_MUL;
              end else begin
                err_d   = 1'b1;
                state_d = cds_pkg::S_FINISH;
              end
            end
          endcase
        end
      end
      // one day per cycle; a year boundary leaves for the leap flag refresh
      cds_pkg::S_STEP: begin
        if (cnt_q == '0) begin
          state_d = cds_pkg::S_FINISH;
        end else begin
          cnt_d = cnt_q - COUNT_BITS'(1);
          if (op_q == cds_pkg::OP_ADD) begin
            if ((cur_month_q == MonthW'(12)) && (cur_day_q >= DayW'(31))) begin
              if (cur_year_q >= YearMax) begin
                err_d   = 1'b1;
                state_d = cds_pkg::S_FINISH;
              end else begin
                cur_year_d  = cur_year_q + YearOne;
                cur_month_d = MonthW'(1);
                cur_day_d   = DayW'(1);
                state_d     = cds_pkg::S_LEAP_MUL;
              end
            end else if (cur_day_q >= cds_pkg::month_days(cur_month_q, leap_q)) begin
              cur_month_d = cur_month_q + MonthW'(1);
              cur_day_d   = DayW'(1);
            end else begin
              cur_day_d = cur_day_q + DayW'(1);
            end
          end else begin
            if ((cur_day_q <= DayW'(1)) && (cur_month_q == MonthW'(1))) begin
              if (cur_year_q <= YearOne) begin
                err_d   = 1'b1;
                state_d = cds_pkg::S_FINISH;
              end else begin
                cur_year_d  = cur_year_q - YearOne;
                cur_month_d = MonthW'(12);
                cur_day_d   = DayW'(31);
                state_d     = cds_pkg::S_LEAP_MUL;
              end
            end else if (cur_day_q <= DayW'(1)) begin
              cur_month_d = cur_month_q - MonthW'(1);
              cur_day_d   = cds_pkg::month_days(cur_month_q - MonthW'(1), leap_q);
            end else begin
              cur_day_d = cur_day_q - DayW'(1);
            end
          end
        end
      end
      // refresh the leap flag of the stored year
      cds_pkg::S_LEAP_MUL: begin
        state_d = cds_pkg::S_LEAP_SET;
      end
      cds_pkg::S_LEAP_SET: begin
        leap_d  = leap_calc;
        state_d = (op_q == cds_pkg::OP_LOAD) ? cds_pkg::S_FINISH : cds_pkg::S_STEP;
      end
      // day number of the selected date into the accumulator
      cds_pkg::S_DIFF_MUL: begin
        state_d = cds_pkg::S_DIFF_DIV;
      end
      cds_pkg::S_DIFF_DIV: begin
        state_d = cds_pkg::S_DIFF_SUM1;
      end
      cds_pkg::S_DIFF_SUM1: begin
        acc_d   = phase_q ? (acc_q - term_years) : (acc_q + term_years);
        state_d = cds_pkg::S_DIFF_SUM2;
      end
      cds_pkg::S_DIFF_SUM2: begin
        acc_d = phase_q ? (acc_q - term_days) : (acc_q + term_days);
        if (phase_q) begin
          state_d = cds_pkg::S_FINISH;
        end else begin
          phase_d = 1'b1;
          state_d = cds_pkg::S_DIFF_MUL;
        end
      end
      // hand the result to the output register once it is free
      cds_pkg::S_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = cds_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = cds_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cds_pkg::S_IDLE;
      op_q        <= cds_pkg::OP_LOAD;
      cur_year_q  <= YEAR_BITS'(2000);
      cur_month_q <= MonthW'(1);
      cur_day_q   <= DayW'(1);
      leap_q      <= 1'b1;
      cnt_q       <= '0;
      err_q       <= 1'b0;
      acc_q       <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      cur_year_q  <= cur_year_d;
      cur_month_q <= cur_month_d;
      cur_day_q   <= cur_day_d;
      leap_q      <= leap_d;
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      acc_q       <= acc_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request capture and multiplier pipeline
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      yr_in_q <= in_i.in_year;
      mo_in_q <= in_i.in_month;
      dy_in_q <= in_i.in_day;
    end
    if (prod_en) begin
      prod_q <= prod_d;
    end
    if (state_q == cds_pkg::S_DIFF_DIV) begin
      q100_q  <= q100;
      dleap_q <= leap_calc;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_year_q  <= cur_year_q;
      out_month_q <= cur_month_q;
      out_day_q   <= cur_day_q;
      out_diff_q  <= acc_q;
      out_err_q   <= err_q;
    end
  end

  assign in_i.ready           = (state_q == cds_pkg::S_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.out_year       = out_year_q;
  assign out_o.out_month      = out_month_q;
  assign out_o.out_day        = out_day_q;
  assign out_o.day_difference = out_diff_q;
  assign out_o.error          = out_err_q;

  // stored date never leaves its field ranges
  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_month_q >= MonthW'(1)) && (cur_month_q <= MonthW'(12)))
    else $error("stored month out of range");

  a_day_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_day_q != '0)
    else $error("stored day is zero");

  // an accepted request always leaves the idle state
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> (state_q != cds_pkg::S_IDLE))
    else $error("request accepted without leaving idle");

  // a new result appears only out of the finishing state
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == cds_pkg::S_FINISH))
    else $error("result raised outside the finishing state");

endmodule
